// File: hw/rtl/bbns_pkg.sv
`timescale 1ns / 1ps
package bbns_pkg;

    typedef struct packed {
        logic [6:0]         node_index;
        logic signed [19:0] activity;
    } t_in_item;

    typedef struct packed {
        logic [6:0]         node_echo;
        logic signed [31:0] bold_signal;
    } t_out_item;

    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic signed [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quo;
    } t_div_rsp;

    typedef enum logic [5:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_DS1, S_DS2, S_LNORM, S_LSQ, S_LSQ2, S_PVM,
        S_EXP0, S_EXPM, S_EXPA, S_EXPF, S_EXPD, S_DV, S_DVC, S_DIVF, S_T1, S_T2,
        S_DIVQ, S_DQ1, S_DQ2, S_U1, S_U2, S_U3, S_U4, S_WB, S_B1, S_B2, S_DIVB,
        S_B3, S_B4, S_FIN
    } t_state;

    localparam logic signed [31:0] Q_ONE     = 32'sd65536;
    localparam logic signed [31:0] S32_MAX   = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN   = 32'sh80000000;
    localparam logic signed [31:0] C_RTAU_S  = 32'sd100825;
    localparam logic signed [31:0] C_RTAU_F  = 32'sd159844;
    localparam logic signed [31:0] C_RTAU_O  = 32'sd66873;
    localparam logic signed [31:0] C_RALPHA  = 32'sd204800;
    localparam logic signed [31:0] C_RE0     = 32'sd163840;
    localparam logic signed [31:0] C_LOG2_06 = -32'sd48298;
    localparam logic signed [31:0] C_K1V0    = 32'sd726831;
    localparam logic signed [31:0] C_K2V0    = 32'sd52429;
    localparam logic signed [31:0] C_K3V0    = 32'sd131072;
    localparam logic signed [31:0] EXP_HI    = 32'sd983040;
    localparam logic signed [31:0] EXP_LO    = -32'sd1048576;
    localparam logic [16:0]        TS_RESET  = 17'd6554;
    localparam int                 DIV_BITS  = 48;

    typedef logic [15:0][31:0] t_roots;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647) r = S32_MAX;
        else if (x < -66'sd2147483648) r = S32_MIN;
        else r = x[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat32(66'(a) + 66'(b));
    endfunction

    function automatic logic signed [31:0] ssub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat32(66'(a) - 66'(b));
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n_in;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // entry k holds 2^(2^(k-16)) in Q2.30
    function automatic t_roots exp2_roots();
        t_roots      tab;
        logic [63:0] root;
        root = 64'd2 << 30;
        for (int k = 15; k >= 0; k--) begin
            root = isqrt64(root << 30);
            tab[k] = root[31:0];
        end
        return tab;
    endfunction

    localparam t_roots EXP2_ROOT = exp2_roots();

endpackage

// File: hw/rtl/balloon_bold_node_step_unit.sv
`timescale 1ns / 1ps
// Balloon-Windkessel hemodynamic step for up to N_NODES nodes. Each input beat advances one
// node's state (s, f, v, q in signed Q15.16) by one Euler step of size time_step and returns
// that node's BOLD signal. After reset a clearing pass over every node puts each node at
// rest; input is stalled meanwhile, configuration writes are taken at any time. An item
// finishes sooner when the volume is not positive or a divisor is zero. The time is set
// by the shared radix-2 divider (three divisions), the bit-serial log2 (up to 30 normalize
// steps plus 16 squarings) and up to two exp2 passes (up to 16 multiplies each); log2 and
// exp2 share one 33x33 multiplier. Input is stalled while an item is in progress; a finished
// result waits in the output register. A node index not below N_NODES gives a zero BOLD
// result and touches no state.
module balloon_bold_node_step_unit #(
    parameter int N_NODES = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  bbns_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output bbns_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [16:0]          i_cfg_data
);
    import bbns_pkg::*;

    localparam int AW = (N_NODES > 1) ? $clog2(N_NODES) : 1;
    localparam int IW = ((AW > 7) ? AW : 7) + 1;

    t_state r_state, n_state;

    logic [127:0]       mem [N_NODES];
    logic [127:0]       r_rdata;
    logic [AW-1:0]      r_clr;
    logic [16:0]        r_time_step;
    logic               r_ovalid;
    t_out_item          r_out;

    logic [6:0]         r_node;
    logic signed [31:0] r_x, r_s, r_f, r_v, r_q;
    logic signed [31:0] r_t, r_ds, r_dv, r_dq, r_pv, r_term, r_er, r_bold;
    logic [30:0]        r_m;
    logic [4:0]         r_p;
    logic [15:0]        r_frac;
    logic [3:0]         r_k;
    logic [15:0]        r_fr;
    logic [31:0]        r_acc;
    logic [4:0]         r_sh;
    logic               r_which;
    logic signed [65:0] r_prod;

    logic signed [32:0] mul_a, mul_b;
    logic signed [31:0] qm;
    logic               accept, fin_go, in_range;
    logic [IW-1:0]      node_ext;
    logic [AW-1:0]      addr;
    logic [IW-1:0]      wb_ext;
    logic [AW-1:0]      wb_addr;
    logic signed [31:0] rd_s, rd_f, rd_v, rd_q;
    logic [31:0]        sq;
    logic [15:0]        lint;
    logic signed [31:0] logv;
    logic signed [5:0]  ip6, sh6;
    logic               exp_hi, exp_lo;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    assign node_ext = IW'(i_in_data.node_index);
    assign in_range = node_ext < IW'(N_NODES);
    assign addr     = node_ext[AW-1:0];
    assign wb_ext   = IW'(r_node);
    assign wb_addr  = wb_ext[AW-1:0];
    assign accept   = i_in_valid && !o_in_stall;
    assign fin_go   = !r_ovalid || !i_out_stall;

    assign rd_s = $signed(r_rdata[127:96]);
    assign rd_f = $signed(r_rdata[95:64]);
    assign rd_v = $signed(r_rdata[63:32]);
    assign rd_q = $signed(r_rdata[31:0]);

    assign qm     = sat32(r_prod >>> 16);
    assign sq     = r_prod[61:30];
    assign lint   = {11'd0, r_p} - 16'd16;
    assign logv   = $signed({lint, r_frac});
    assign ip6    = $signed(qm[21:16]);
    assign sh6    = 6'sd14 - ip6;
    assign exp_hi = qm >= EXP_HI;
    assign exp_lo = qm < EXP_LO;

    bbns_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == AW'(N_NODES - 1)) n_state = S_IDLE;
            S_IDLE:  if (accept) n_state = in_range ? S_LOAD : S_FIN;
            S_LOAD:  n_state = S_DS1;
            S_DS1:   n_state = S_DS2;
            S_DS2:   n_state = (r_v <= 32'sd0) ? S_DV : S_LNORM;
            S_LNORM: if (r_m[30]) n_state = S_LSQ;
            S_LSQ:   n_state = S_LSQ2;
            S_LSQ2:  n_state = (r_k == 4'd0) ? S_PVM : S_LSQ;
            S_PVM:   n_state = S_EXP0;
            S_EXP0:  n_state = (exp_hi || exp_lo) ? S_EXPD : S_EXPM;
            S_EXPM: begin
                if (r_fr[r_k]) n_state = S_EXPA;
                else if (r_k == 4'd0) n_state = S_EXPF;
            end
            S_EXPA:  n_state = (r_k == 4'd0) ? S_EXPF : S_EXPM;
            S_EXPF:  n_state = S_EXPD;
            S_EXPD:  n_state = r_which ? S_T1 : S_DV;
            S_DV:    n_state = S_DVC;
            S_DVC:   n_state = S_DIVF;
            S_DIVF:  if (div_rsp.done) n_state = S_EXP0;
            S_T1:    n_state = S_T2;
            S_T2:    n_state = S_DIVQ;
            S_DIVQ:  if (div_rsp.done) n_state = S_DQ1;
            S_DQ1:   n_state = S_DQ2;
            S_DQ2:   n_state = S_U1;
            S_U1:    n_state = S_U2;
            S_U2:    n_state = S_U3;
            S_U3:    n_state = S_U4;
            S_U4:    n_state = S_WB;
            S_WB:    n_state = S_B1;
            S_B1:    n_state = S_B2;
            S_B2:    n_state = S_DIVB;
            S_DIVB:  if (div_rsp.done) n_state = S_B3;
            S_B3:    n_state = S_B4;
            S_B4:    n_state = S_FIN;
            S_FIN:   if (fin_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // multiplier operands and divider requests
    always_comb begin
        mul_a         = 33'sd0;
        mul_b         = 33'sd0;
        div_req.start = 1'b0;
        div_req.num   = r_q;
        div_req.den   = r_v;
        case (r_state)
            S_LOAD: begin mul_a = 33'(C_RTAU_S); mul_b = 33'(rd_s); end
            S_DS1:  begin mul_a = 33'(C_RTAU_F); mul_b = 33'(ssub(r_f, Q_ONE)); end
            S_LSQ:  begin mul_a = $signed({2'b0, r_m}); mul_b = $signed({2'b0, r_m}); end
            S_PVM:  begin mul_a = 33'(C_RALPHA); mul_b = 33'(logv); end
            S_EXPM: begin
                mul_a = $signed({1'b0, r_acc});
                mul_b = $signed({1'b0, EXP2_ROOT[r_k]});
            end
            S_DV:   begin mul_a = 33'(C_RTAU_O); mul_b = 33'(ssub(r_f, r_pv)); end
            S_DVC: begin
                div_req.start = 1'b1;
                div_req.num   = Q_ONE;
                div_req.den   = r_f;
            end
            S_DIVF: begin mul_a = 33'(C_LOG2_06); mul_b = 33'(div_rsp.quo); end
            S_EXPD: begin mul_a = 33'(r_f); mul_b = 33'(ssub(Q_ONE, r_er)); end
            S_T1:   begin mul_a = 33'(qm); mul_b = 33'(C_RE0); end
            S_T2:   div_req.start = 1'b1;
            S_DIVQ: begin mul_a = 33'(r_pv); mul_b = 33'(div_rsp.quo); end
            S_DQ1:  begin mul_a = 33'(C_RTAU_O); mul_b = 33'(ssub(r_term, qm)); end
            S_DQ2:  begin mul_a = $signed({16'd0, r_time_step}); mul_b = 33'(r_s); end
            S_U1:   begin mul_a = $signed({16'd0, r_time_step}); mul_b = 33'(r_ds); end
            S_U2:   begin mul_a = $signed({16'd0, r_time_step}); mul_b = 33'(r_dv); end
            S_U3:   begin mul_a = $signed({16'd0, r_time_step}); mul_b = 33'(r_dq); end
            S_WB:   begin mul_a = 33'(C_K1V0); mul_b = 33'(ssub(Q_ONE, r_q)); end
            S_B1:   begin mul_a = 33'(C_K3V0); mul_b = 33'(ssub(Q_ONE, r_v)); end
            // started right before the wait so a zero divisor answer is not missed
            S_B2:   div_req.start = 1'b1;
            S_DIVB: begin mul_a = 33'(C_K2V0); mul_b = 33'(ssub(Q_ONE, div_rsp.quo)); end
            default: begin
                mul_a = 33'sd0;
                mul_b = 33'sd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // state memory: {s, f, v, q} per node
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            mem[r_clr] <= {32'sd0, Q_ONE, Q_ONE, Q_ONE};
        end else if (r_state == S_WB) begin
            mem[wb_addr] <= {r_s, r_f, r_v, r_q};
        end
        if (accept) begin
            r_rdata <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_ovalid    <= 1'b0;
            r_time_step <= TS_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + AW'(1);
            if (i_cfg_valid) r_time_step <= i_cfg_data;
            if (r_state == S_FIN && fin_go) r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_node <= i_in_data.node_index;
                r_x    <= 32'(i_in_data.activity);
                r_bold <= 32'sd0;
            end
            S_LOAD: begin
                r_s <= rd_s;
                r_f <= rd_f;
                r_v <= rd_v;
                r_q <= rd_q;
            end
            S_DS1: r_t <= ssub(r_x, qm);
            S_DS2: begin
                r_ds <= ssub(r_t, qm);
                r_pv <= 32'sd0;
                r_m  <= r_v[30:0];
                r_p  <= 5'd30;
            end
            S_LNORM: begin
                r_k    <= 4'd15;
                r_frac <= 16'd0;
                if (!r_m[30]) begin
                    r_m <= {r_m[29:0], 1'b0};
                    r_p <= r_p - 5'd1;
                end
            end
            S_LSQ2: begin
                if (sq[31]) begin
                    r_m         <= sq[31:1];
                    r_frac[r_k] <= 1'b1;
                end else begin
                    r_m <= sq[30:0];
                end
                r_k <= r_k - 4'd1;
            end
            S_PVM: r_which <= 1'b0;
            S_EXP0: begin
                if (exp_hi) r_er <= S32_MAX;
                else r_er <= 32'sd0;
                r_fr  <= qm[15:0];
                r_sh  <= sh6[4:0];
                r_acc <= 32'h4000_0000;
                r_k   <= 4'd15;
            end
            S_EXPM: if (!r_fr[r_k] && r_k != 4'd0) r_k <= r_k - 4'd1;
            S_EXPA: begin
                r_acc <= sq;
                r_k   <= r_k - 4'd1;
            end
            S_EXPF: r_er <= $signed(r_acc >> r_sh);
            S_EXPD: if (!r_which) r_pv <= r_er;
            S_DVC:  r_dv <= qm;
            S_DIVF: r_which <= 1'b1;
            S_T2:   r_term <= qm;
            S_DQ2:  r_dq <= qm;
            S_U1:   r_f <= sadd(r_f, qm);
            S_U2:   r_s <= sadd(r_s, qm);
            S_U3:   r_v <= sadd(r_v, qm);
            S_U4:   r_q <= sadd(r_q, qm);
            S_B1:   r_bold <= qm;
            S_B2:   r_t <= qm;
            S_B3:   r_bold <= sadd(r_bold, qm);
            S_B4:   r_bold <= sadd(r_bold, r_t);
            S_FIN: begin
                if (fin_go) begin
                    r_out.node_echo   <= r_node;
                    r_out.bold_signal <= r_bold;
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // divider answers only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIVF || r_state == S_DIVQ || r_state == S_DIVB))
        else $error("divider done outside a wait state");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("second beat taken while an item is in progress");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_FIN)
        else $error("result raised outside the finish step");

    a_wb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WB |-> IW'(r_node) < IW'(N_NODES))
        else $error("write back to a node out of range");

endmodule

// File: hw/rtl/bbns_div.sv
`timescale 1ns / 1ps
module bbns_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bbns_pkg::t_div_req i_req,
    output bbns_pkg::t_div_rsp o_rsp
);
    import bbns_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [5:0]          r_cnt;
    logic [DIV_BITS-1:0] r_dd;
    logic [31:0]         r_rem;
    logic [31:0]         r_ub;
    logic                r_neg;
    logic signed [31:0]  r_quo;

    logic [32:0]         rem_sh;
    logic [32:0]         diff;
    logic                ge;
    logic [DIV_BITS-1:0] qmag;
    logic [31:0]         ua;
    logic [31:0]         ub;

    assign ua     = i_req.num[31] ? 32'(-i_req.num) : 32'(i_req.num);
    assign ub     = i_req.den[31] ? 32'(-i_req.den) : 32'(i_req.den);
    assign rem_sh = {r_rem, r_dd[DIV_BITS-1]};
    assign diff   = rem_sh - {1'b0, r_ub};
    assign ge     = rem_sh >= {1'b0, r_ub};
    assign qmag   = {r_dd[DIV_BITS-2:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                if (i_req.den == 32'sd0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy && r_cnt == 6'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            if (i_req.den == 32'sd0) begin
                if (i_req.num > 32'sd0) r_quo <= S32_MAX;
                else if (i_req.num < 32'sd0) r_quo <= S32_MIN;
                else r_quo <= 32'sd0;
            end
            r_cnt <= 6'(DIV_BITS - 1);
            r_dd  <= {ua, 16'd0};
            r_rem <= 32'd0;
            r_ub  <= ub;
            r_neg <= i_req.num[31] ^ i_req.den[31];
        end else if (r_busy) begin
            r_rem <= ge ? diff[31:0] : rem_sh[31:0];
            r_dd  <= qmag;
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                // truncated magnitude, then sign and saturate
                if (!r_neg) begin
                    r_quo <= (qmag > DIV_BITS'(32'h7fffffff)) ? S32_MAX
                                                               : $signed(qmag[31:0]);
                end else begin
                    r_quo <= (qmag > DIV_BITS'(33'h80000000)) ? S32_MIN
                                                               : $signed(-qmag[31:0]);
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule
